// File: sv/pczs_pkg.sv
// pczs_pkg: shared types and constants for the portal counterpart zone selector
// no dependencies
`default_nettype none
package pczs_pkg;
	localparam int REACH_WIDEN = 16;

	localparam logic [2:0] CFG_PMIN_X = 3'd0;
	localparam logic [2:0] CFG_PMIN_Y = 3'd1;
	localparam logic [2:0] CFG_PMIN_Z = 3'd2;
	localparam logic [2:0] CFG_PMAX_X = 3'd3;
	localparam logic [2:0] CFG_PMAX_Y = 3'd4;
	localparam logic [2:0] CFG_PMAX_Z = 3'd5;
	localparam logic [2:0] CFG_HOLDER = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL1,
		ST_MUL2,
		ST_UPD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic mul1;
		logic mul2;
		logic update;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic is_last;
	} status_t;
endpackage
`default_nettype wire

// File: sv/pczs_if.sv
// pczs_if: valid/ready stream interface with a generic payload
// depends on nothing
`default_nettype none
interface pczs_if #(
	parameter int W = 8
) (
	input wire logic clk
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/pczs_ctrl.sv
// pczs_ctrl: sequencer for one zone item
// depends on pczs_pkg
`default_nettype none
module pczs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               out_full,
	input  wire logic               out_take,
	input  wire pczs_pkg::status_t  status,
	output pczs_pkg::cmd_t          cmd
);
	pczs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pczs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pczs_pkg::ST_IDLE: if (in_valid) state_d = pczs_pkg::ST_PREP;
			pczs_pkg::ST_PREP: state_d = pczs_pkg::ST_MUL1;
			pczs_pkg::ST_MUL1: state_d = pczs_pkg::ST_MUL2;
			pczs_pkg::ST_MUL2: state_d = pczs_pkg::ST_UPD;
			pczs_pkg::ST_UPD: begin
				state_d = status.is_last ? pczs_pkg::ST_OUT : pczs_pkg::ST_IDLE;
			end
			pczs_pkg::ST_OUT: if (!out_full || out_take) state_d = pczs_pkg::ST_IDLE;
			default: state_d = pczs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == pczs_pkg::ST_IDLE);
		cmd = '0;
		cmd.load = (state_q == pczs_pkg::ST_IDLE) && in_valid;
		cmd.prep = (state_q == pczs_pkg::ST_PREP);
		cmd.mul1 = (state_q == pczs_pkg::ST_MUL1);
		cmd.mul2 = (state_q == pczs_pkg::ST_MUL2);
		cmd.update = (state_q == pczs_pkg::ST_UPD);
		cmd.clear = (state_q == pczs_pkg::ST_OUT) && (!out_full || out_take);
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> in_ready) else $error("load outside idle");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.prep) else $error("prep does not follow load");
	a_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul1 |=> cmd.mul2) else $error("mul2 does not follow mul1");
endmodule
`default_nettype wire

// File: sv/pczs_dp.sv
// pczs_dp: overlap volume and centre distance datapath with best trackers
// depends on pczs_pkg
`default_nettype none
module pczs_dp #(
	parameter int COORD_BITS = 20,
	parameter int ID_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire pczs_pkg::cmd_t               cmd,
	output pczs_pkg::status_t                 status,
	input  wire logic [ID_BITS-1:0]           zone_id,
	input  wire logic signed [COORD_BITS-1:0] zmin [3],
	input  wire logic signed [COORD_BITS-1:0] zmax [3],
	input  wire logic                         last_zone,
	input  wire logic signed [COORD_BITS-1:0] pmin [3],
	input  wire logic signed [COORD_BITS-1:0] pmax [3],
	input  wire logic [ID_BITS-1:0]           holder_id,
	output logic [ID_BITS-1:0]                res_id,
	output logic                              res_found,
	output logic                              res_overlap
);
	localparam int CW = COORD_BITS + 2;      // widened coordinate
	localparam int EW = COORD_BITS + 3;      // overlap extent / doubled offset
	localparam int VW = 3 * EW;
	localparam int DW = 2 * EW + 2;

	logic [ID_BITS-1:0]           id_q;
	logic                         last_q;
	logic signed [COORD_BITS-1:0] zmin_q [3];
	logic signed [COORD_BITS-1:0] zmax_q [3];
	logic signed [COORD_BITS-1:0] pmin_q [3];
	logic signed [COORD_BITS-1:0] pmax_q [3];
	logic [ID_BITS-1:0]           holder_q;

	// prep and multiply stage results
	logic [EW-1:0] ext_q [3];
	logic [EW-1:0] mag_q [3];
	logic          ov_ok_q, gs_ok_q, cand_q;
	logic [2*EW-1:0] p01_q;
	logic [VW-1:0]   vol_q;
	logic [DW-1:0]   dist_q;

	logic          ov_found_q, gs_found_q;
	logic [VW-1:0] best_vol_q;
	logic [DW-1:0] best_dist_q;
	logic [ID_BITS-1:0] ov_id_q, gs_id_q;

	logic [1:0] facing;
	logic signed [CW-1:0] pe [3];
	logic [EW-1:0] ext_c [3];
	logic [EW-1:0] mag_c [3];
	logic ov_ok_c, valid_c;
	logic [1:0] dax;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q <= zone_id;
			last_q <= last_zone;
			zmin_q <= zmin;
			zmax_q <= zmax;
			pmin_q <= pmin;
			pmax_q <= pmax;
			holder_q <= holder_id;
		end
	end

	always_comb begin
		logic signed [CW-1:0] rlo, rhi, lo, hi, zl, zh;
		logic signed [EW-1:0] off;
		for (int i = 0; i < 3; i++) begin
			pe[i] = CW'(pmax_q[i]) - CW'(pmin_q[i]);
		end
		facing = 2'd0;
		if (pe[1] < pe[0]) facing = 2'd1;
		if (pe[2] < ((facing == 2'd1) ? pe[1] : pe[0])) facing = 2'd2;
		ov_ok_c = 1'b1;
		valid_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			zl = CW'(zmin_q[i]);
			zh = CW'(zmax_q[i]);
			rlo = CW'(pmin_q[i]);
			rhi = CW'(pmax_q[i]);
			if (facing == 2'(i)) begin
				rlo = rlo - CW'(pczs_pkg::REACH_WIDEN);
				rhi = rhi + CW'(pczs_pkg::REACH_WIDEN);
			end
			lo = (rlo > zl) ? rlo : zl;
			hi = (rhi < zh) ? rhi : zh;
			if (zl > zh) valid_c = 1'b0;
			if (hi <= lo) ov_ok_c = 1'b0;
			ext_c[i] = EW'(hi - lo);
			off = (EW'(zmin_q[i]) + EW'(zmax_q[i])) - (EW'(pmin_q[i]) + EW'(pmax_q[i]));
			mag_c[i] = off[EW-1] ? EW'(-off) : EW'(off);
		end
		dax = 2'd0;
		if (mag_c[1] > mag_c[0]) dax = 2'd1;
		if (mag_c[2] > ((dax == 2'd1) ? mag_c[1] : mag_c[0])) dax = 2'd2;
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			ext_q <= ext_c;
			mag_q <= mag_c;
			cand_q <= (id_q != holder_q);
			ov_ok_q <= valid_c && ov_ok_c;
			gs_ok_q <= ((mag_c[0] | mag_c[1] | mag_c[2]) != '0) && (dax == facing);
		end
		if (cmd.mul1) begin
			p01_q <= ext_q[0] * ext_q[1];
			dist_q <= DW'(mag_q[0] * mag_q[0]);
		end
		if (cmd.mul2) begin
			vol_q <= VW'(p01_q) * VW'(ext_q[2]);
			dist_q <= dist_q + DW'(mag_q[1] * mag_q[1]) + DW'(mag_q[2] * mag_q[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_found_q <= 1'b0;
			gs_found_q <= 1'b0;
			best_vol_q <= '0;
			best_dist_q <= '0;
			ov_id_q <= '0;
			gs_id_q <= '0;
		end else if (cmd.clear) begin
			ov_found_q <= 1'b0;
			gs_found_q <= 1'b0;
			best_vol_q <= '0;
			best_dist_q <= '0;
			ov_id_q <= '0;
			gs_id_q <= '0;
		end else if (cmd.update && cand_q) begin
			if (ov_ok_q && (!ov_found_q || vol_q > best_vol_q ||
					(vol_q == best_vol_q && id_q < ov_id_q))) begin
				ov_found_q <= 1'b1;
				best_vol_q <= vol_q;
				ov_id_q <= id_q;
			end
			if (gs_ok_q && (!gs_found_q || dist_q < best_dist_q ||
					(dist_q == best_dist_q && id_q < gs_id_q))) begin
				gs_found_q <= 1'b1;
				best_dist_q <= dist_q;
				gs_id_q <= id_q;
			end
		end
	end

	assign status.is_last = last_q;
	assign res_found = ov_found_q || gs_found_q;
	assign res_overlap = ov_found_q;
	assign res_id = ov_found_q ? ov_id_q : (gs_found_q ? gs_id_q : '0);

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> !ov_found_q && !gs_found_q) else $error("trackers not cleared");
	a_ovid: assert property (@(posedge clk) disable iff (!arst_n)
		ov_found_q |-> ov_id_q != holder_q || $past(cmd.load))
		else $error("holder chosen");
endmodule
`default_nettype wire

// File: sv/portal_counterpart_zone_select.sv
// portal_counterpart_zone_select: top level, config registers and output register
// depends on pczs_pkg, pczs_if, pczs_ctrl, pczs_dp
//
// Usage: seven configuration registers (portal box min x/y/z, max x/y/z, holder
// id) are written through cfg at index 0..6; the user must write them only while
// the block is idle, which the block itself does not enforce. Zone items arrive
// on zin, one zone box and id per transaction, last_zone marking the end of a
// list. Each item runs through a fixed sequence: load, prep (facing axis,
// overlaps, centre offsets), two multiply steps (volume and squared distance)
// and update of the best trackers; the next zone is accepted only once the four
// steps after the load are through. The last item of a list adds an output step,
// in which its transaction on zout (chosen id, found, by_overlap) is registered
// and the trackers are cleared; the next zone is accepted after that step.
// The result sits in an output register; if the receiver stalls, zones are still
// accepted, but the output step of the next list holds until the earlier result
// is taken.
// Reset clears configuration to zero, the trackers and the output valid.
`default_nettype none
module portal_counterpart_zone_select #(
	parameter int COORD_BITS = 20,
	parameter int ID_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	pczs_if.sink     cfg,
	pczs_if.sink     zin,
	pczs_if.source   zout
);
	localparam int ZW = ID_BITS + 6 * COORD_BITS + 1;
	localparam int VALW = (COORD_BITS > ID_BITS) ? COORD_BITS : ID_BITS;

	logic signed [COORD_BITS-1:0] pmin_q [3];
	logic signed [COORD_BITS-1:0] pmax_q [3];
	logic [ID_BITS-1:0]           holder_q;
	logic [2:0]                   cfg_idx;
	logic [VALW-1:0]              cfg_val;

	assign cfg.ready = 1'b1;
	assign cfg_idx = cfg.data[VALW+2:VALW];
	assign cfg_val = cfg.data[VALW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmin_q <= '{default: '0};
			pmax_q <= '{default: '0};
			holder_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_idx)
				pczs_pkg::CFG_PMIN_X: pmin_q[0] <= cfg_val[COORD_BITS-1:0];
				pczs_pkg::CFG_PMIN_Y: pmin_q[1] <= cfg_val[COORD_BITS-1:0];
				pczs_pkg::CFG_PMIN_Z: pmin_q[2] <= cfg_val[COORD_BITS-1:0];
				pczs_pkg::CFG_PMAX_X: pmax_q[0] <= cfg_val[COORD_BITS-1:0];
				pczs_pkg::CFG_PMAX_Y: pmax_q[1] <= cfg_val[COORD_BITS-1:0];
				pczs_pkg::CFG_PMAX_Z: pmax_q[2] <= cfg_val[COORD_BITS-1:0];
				pczs_pkg::CFG_HOLDER: holder_q <= cfg_val[ID_BITS-1:0];
				default: ;
			endcase
		end
	end

	// zin payload: {last_zone, zmax z/y/x, zmin z/y/x, zone_id}
	logic [ID_BITS-1:0]           zone_id;
	logic signed [COORD_BITS-1:0] zmin [3];
	logic signed [COORD_BITS-1:0] zmax [3];
	logic                         last_zone;

	always_comb begin
		zone_id = zin.data[ID_BITS-1:0];
		for (int i = 0; i < 3; i++) begin
			zmin[i] = zin.data[ID_BITS + i*COORD_BITS +: COORD_BITS];
			zmax[i] = zin.data[ID_BITS + (i+3)*COORD_BITS +: COORD_BITS];
		end
		last_zone = zin.data[ZW-1];
	end

	pczs_pkg::cmd_t    cmd;
	pczs_pkg::status_t status;
	logic out_valid_q;
	logic [ID_BITS+1:0] out_q;
	logic [ID_BITS-1:0] res_id;
	logic res_found, res_overlap;

	pczs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (zin.valid),
		.in_ready (zin.ready),
		.out_full (out_valid_q),
		.out_take (zout.ready),
		.status   (status),
		.cmd      (cmd)
	);

	pczs_dp #(
		.COORD_BITS (COORD_BITS),
		.ID_BITS    (ID_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.zone_id     (zone_id),
		.zmin        (zmin),
		.zmax        (zmax),
		.last_zone   (last_zone),
		.pmin        (pmin_q),
		.pmax        (pmax_q),
		.holder_id   (holder_q),
		.res_id      (res_id),
		.res_found   (res_found),
		.res_overlap (res_overlap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.clear) begin
			out_valid_q <= 1'b1;
		end else if (zout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload: {by_overlap, found, target_zone_id}
	always_ff @(posedge clk) begin
		if (cmd.clear) out_q <= {res_overlap, res_found, res_id};
	end

	assign zout.valid = out_valid_q;
	assign zout.data = out_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		zout.valid && !zout.ready |=> zout.valid && $stable(zout.data))
		else $error("output changed under stall");
	a_no_lost: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !out_valid_q || zout.ready) else $error("result overwritten");
	a_overlap_found: assert property (@(posedge clk) disable iff (!arst_n)
		zout.valid |-> !zout.data[ID_BITS+1] || zout.data[ID_BITS])
		else $error("by_overlap without found");
endmodule
`default_nettype wire
